>>> hw/rtl/rppc_pkg.sv
// ----------------------------------------------------------------------------
// rppc_pkg
// Shared types and constants of the row-pair Pearson correlation engine.
// ----------------------------------------------------------------------------
package rppc_pkg;

	localparam int DEF_MAX_ROWS     = 16;
	localparam int DEF_MAX_COLUMNS  = 256;

	localparam int SAMPLE_W         = 16;
	localparam int ROW_W            = 4;
	localparam int COL_W            = 8;
	localparam int ACTIVE_ROWS_W    = 5;
	localparam int ACTIVE_COLUMNS_W = 9;
	localparam int CFG_DATA_W       = 9;
	localparam int CFG_INDEX_W      = 2;

	localparam int RESET_ACTIVE_ROWS    = 16;
	localparam int RESET_ACTIVE_COLUMNS = 256;

	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_ROWS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_COLUMNS = 2'd1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Quotient of 2^32 * cov^2 / (var_a * var_b) is at most 2^32: 33 bits.
	localparam int DIV_STEPS  = 33;
	localparam int QUO_W      = 34;
	localparam int SQRT_STEPS = 17;
	localparam int ROOT_W     = 17;
	localparam int SQREM_W    = 20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_PRODS,
		ST_VARS,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_FINISH
	} state_t;

endpackage

>>> hw/rtl/row_pair_pearson_correlation.sv
// ----------------------------------------------------------------------------
// row_pair_pearson_correlation
// Sample matrix in a synchronous memory with two read ports, and a sequencer
// that reduces two rows to their Pearson correlation in Q1.15.
// ----------------------------------------------------------------------------
// A query walks its active columns over the two memory read ports, forms the sums
// and variances, runs two wide multiplies, a 33-step divider and a 17-step square
// root, and presents its result beat, held back while the output stalls; a row out
// of range or a zero variance skips to the beat. No query or load is taken until
// the beat is presented; loads are taken every cycle while idle. Reset clears control
// state and the configuration registers; datapath registers and memory are not reset.
module row_pair_pearson_correlation
	import rppc_pkg::*;
#(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [CFG_INDEX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [ROW_W-1:0]            row_index,
	input  logic [COL_W-1:0]            column_index,
	input  logic [ROW_W-1:0]            other_row,
	input  logic signed [SAMPLE_W-1:0]  sample,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]  correlation,
	output logic [ROW_W-1:0]            first_row,
	output logic [ROW_W-1:0]            second_row,
	output logic                        zero_variance
);

	localparam int RA_W   = $clog2(MAX_ROWS);
	localparam int CA_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int AW     = RA_W + CA_W;
	localparam int N_MAX  = (MAX_COLUMNS < 511) ? MAX_COLUMNS : 511;
	localparam int N_W    = $clog2(N_MAX + 1);
	localparam int SW     = SAMPLE_W + N_W;
	localparam int QW     = 2 * SAMPLE_W - 1 + N_W;
	localparam int MW     = 2 * SAMPLE_W - 2 + 2 * N_W;
	localparam int V      = MW + 1;
	localparam int H      = (MW + 1) / 2;
	localparam int PW     = 2 * MW;
	localparam int RST_ROWS = (RESET_ACTIVE_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_ACTIVE_ROWS;
	localparam int RST_COLS =
		(RESET_ACTIVE_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : RESET_ACTIVE_COLUMNS;

	state_t state_q, state_d;

	logic [ACTIVE_ROWS_W-1:0]    active_rows_q;
	logic [ACTIVE_COLUMNS_W-1:0] active_columns_q;
	logic [N_W-1:0]              n_w;

	logic signed [SAMPLE_W-1:0] mem_q [2**AW];

	logic [ROW_W-1:0] ra_q, rb_q;
	logic             flat_q, neg_q;
	logic [N_W-1:0]   issue_q;
	logic             issuing, accum_done;
	logic [31:0]      ra_ext, rb_ext, issue_ext, wr_row_ext, wr_col_ext;
	logic [AW-1:0]    addr_a, addr_b, addr_w;
	logic             in_acc, load_ok, rows_ok;

	logic                       rd_v_s1, v_s2;
	logic signed [SAMPLE_W-1:0] a_s1, b_s1, a_s2, b_s2;
	logic signed [31:0]         paa_c, pbb_c, pab_c, paa_s2, pbb_s2, pab_s2;
	logic signed [SW-1:0]       sa_q, sb_q;
	logic signed [QW-1:0]       saa_q, sbb_q, sab_q;

	logic signed [V-1:0] nsaa_c, nsbb_c, nsab_c, sasa_c, sbsb_c, sasb_c;
	logic signed [V-1:0] nsaa_q, nsbb_q, nsab_q, sasa_q, sbsb_q, sasb_q;
	logic signed [V-1:0] vaa_q, vbb_q, vab_q, mag_c;
	logic                flat_c;

	logic [2*H-1:0] mx_q, my_q, pp_c, pp_q;
	logic [1:0]     psh_q, psh_c;
	logic [2:0]     mstep_q;
	logic           msel_q;
	logic [4*H-1:0] acc_q, acc_add, acc_next;

	logic [PW-1:0]  p_q;
	logic [PW:0]    rem_q, div_trial, div_sub;
	logic           div_ge;
	logic [5:0]     dcnt_q;
	logic [QUO_W-1:0] quo_q;

	logic [QUO_W-1:0]   sq_src_q;
	logic [ROOT_W-1:0]  root_q;
	logic [SQREM_W-1:0] sqrem_q, sq_shift, sq_trial;
	logic               sq_ge;
	logic [4:0]         scnt_q;

	logic [ROOT_W:0]   root_inc;
	logic [ROOT_W-1:0] k_c;
	logic signed [SAMPLE_W-1:0] corr_c;
	logic              out_free;

	logic                       out_valid_q, zero_variance_q;
	logic signed [SAMPLE_W-1:0] correlation_q;
	logic [ROW_W-1:0]           first_row_q, second_row_q;

	assign in_stall      = (state_q != ST_IDLE);
	assign in_acc        = in_valid && !in_stall;
	assign out_free      = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign correlation   = correlation_q;
	assign first_row     = first_row_q;
	assign second_row    = second_row_q;
	assign zero_variance = zero_variance_q;

	assign n_w = N_W'(active_columns_q);

	// Configuration registers, clamped into their legal range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q    <= ACTIVE_ROWS_W'(RST_ROWS);
			active_columns_q <= ACTIVE_COLUMNS_W'(RST_COLS);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ACTIVE_ROWS: begin
					if (cfg_data[ACTIVE_ROWS_W-1:0] == '0)
						active_rows_q <= ACTIVE_ROWS_W'(1);
					else if (32'(cfg_data[ACTIVE_ROWS_W-1:0]) > 32'(MAX_ROWS))
						active_rows_q <= ACTIVE_ROWS_W'(MAX_ROWS);
					else
						active_rows_q <= cfg_data[ACTIVE_ROWS_W-1:0];
				end
				REG_ACTIVE_COLUMNS: begin
					if (cfg_data == '0)
						active_columns_q <= ACTIVE_COLUMNS_W'(1);
					else if (32'(cfg_data) > 32'(MAX_COLUMNS))
						active_columns_q <= ACTIVE_COLUMNS_W'(MAX_COLUMNS);
					else
						active_columns_q <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	// Memory addressing: the row sits above the column field.
	assign wr_row_ext = 32'(row_index);
	assign wr_col_ext = 32'(column_index);
	assign ra_ext     = 32'(ra_q);
	assign rb_ext     = 32'(rb_q);
	assign issue_ext  = 32'(issue_q);
	assign addr_w     = {wr_row_ext[RA_W-1:0], wr_col_ext[CA_W-1:0]};
	assign addr_a     = {ra_ext[RA_W-1:0], issue_ext[CA_W-1:0]};
	assign addr_b     = {rb_ext[RA_W-1:0], issue_ext[CA_W-1:0]};
	assign load_ok    = (wr_row_ext < 32'(MAX_ROWS)) && (wr_col_ext < 32'(MAX_COLUMNS));
	assign rows_ok    = ({1'b0, row_index} < active_rows_q) && ({1'b0, other_row} < active_rows_q);

	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_LOAD && load_ok)
			mem_q[addr_w] <= sample;
		a_s1 <= mem_q[addr_a];
		b_s1 <= mem_q[addr_b];
	end

	assign issuing    = (state_q == ST_ACCUM) && (issue_q < n_w);
	assign accum_done = (issue_q == n_w) && !rd_v_s1 && !v_s2;

	assign paa_c = a_s1 * a_s1;
	assign pbb_c = b_s1 * b_s1;
	assign pab_c = a_s1 * b_s1;

	assign nsaa_c = $signed({1'b0, n_w}) * saa_q;
	assign nsbb_c = $signed({1'b0, n_w}) * sbb_q;
	assign nsab_c = $signed({1'b0, n_w}) * sab_q;
	assign sasa_c = sa_q * sa_q;
	assign sbsb_c = sb_q * sb_q;
	assign sasb_c = sa_q * sb_q;

	assign flat_c = vaa_q[V-1] || (vaa_q == '0) || vbb_q[V-1] || (vbb_q == '0);
	assign mag_c  = vab_q[V-1] ? -vab_q : vab_q;

	// Wide multiply: four half-width partial products, one per cycle.
	always_comb begin
		case (mstep_q)
			3'd0: begin
				pp_c  = mx_q[H-1:0] * my_q[H-1:0];
				psh_c = 2'd0;
			end
			3'd1: begin
				pp_c  = mx_q[H-1:0] * my_q[2*H-1:H];
				psh_c = 2'd1;
			end
			3'd2: begin
				pp_c  = mx_q[2*H-1:H] * my_q[H-1:0];
				psh_c = 2'd1;
			end
			default: begin
				pp_c  = mx_q[2*H-1:H] * my_q[2*H-1:H];
				psh_c = 2'd2;
			end
		endcase
		case (psh_q)
			2'd0:    acc_add = {{(2*H){1'b0}}, pp_q};
			2'd1:    acc_add = {{H{1'b0}}, pp_q, {H{1'b0}}};
			default: acc_add = {pp_q, {(2*H){1'b0}}};
		endcase
		acc_next = (mstep_q == 3'd0) ? '0 : acc_q + acc_add;
	end

	// Restoring division: the first step compares without a shift.
	assign div_trial = (dcnt_q == '0) ? rem_q : {rem_q[PW-1:0], 1'b0};
	assign div_ge    = div_trial >= {1'b0, p_q};
	assign div_sub   = div_trial - {1'b0, p_q};

	// Digit-by-digit square root, two radicand bits per step.
	assign sq_shift = {sqrem_q[SQREM_W-3:0], sq_src_q[QUO_W-1:QUO_W-2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = sq_shift >= sq_trial;

	// The coefficient is the largest k with 2k - 1 at most the root.
	assign root_inc = {1'b0, root_q} + (ROOT_W + 1)'(1);
	assign k_c      = root_inc[ROOT_W:1];
	always_comb begin
		if (flat_q)
			corr_c = '0;
		else if (neg_q)
			corr_c = SAMPLE_W'(0) - k_c[SAMPLE_W-1:0];
		else if (k_c[SAMPLE_W-1])
			corr_c = {1'b0, {(SAMPLE_W-1){1'b1}}};
		else
			corr_c = k_c[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && kind == KIND_QUERY)
					state_d = rows_ok ? ST_ACCUM : ST_FINISH;
			end
			ST_ACCUM:  if (accum_done) state_d = ST_PRODS;
			ST_PRODS:  state_d = ST_VARS;
			ST_VARS:   state_d = ST_CHECK;
			ST_CHECK:  state_d = flat_c ? ST_FINISH : ST_MUL;
			ST_MUL:    if (mstep_q == 3'd4 && msel_q) state_d = ST_DIV;
			ST_DIV:    if (dcnt_q == 6'(DIV_STEPS - 1)) state_d = ST_SQRT;
			ST_SQRT:   if (scnt_q == 5'(SQRT_STEPS - 1)) state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control registers of the column walk, the step counters and the output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= '0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			mstep_q     <= '0;
			msel_q      <= 1'b0;
			dcnt_q      <= '0;
			scnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issuing;
			v_s2    <= rd_v_s1;
			if (in_acc)
				issue_q <= '0;
			else if (issuing)
				issue_q <= issue_q + N_W'(1);
			if (state_q == ST_CHECK) begin
				mstep_q <= '0;
				msel_q  <= 1'b0;
			end else if (state_q == ST_MUL) begin
				mstep_q <= (mstep_q == 3'd4) ? 3'd0 : mstep_q + 3'd1;
				if (mstep_q == 3'd4)
					msel_q <= 1'b1;
			end
			dcnt_q <= (state_q == ST_DIV) ? dcnt_q + 6'd1 : '0;
			scnt_q <= (state_q == ST_SQRT) ? scnt_q + 5'd1 : '0;
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		paa_s2 <= paa_c;
		pbb_s2 <= pbb_c;
		pab_s2 <= pab_c;

		if (in_acc && kind == KIND_QUERY) begin
			ra_q   <= row_index;
			rb_q   <= other_row;
			flat_q <= !rows_ok;
			sa_q   <= '0;
			sb_q   <= '0;
			saa_q  <= '0;
			sbb_q  <= '0;
			sab_q  <= '0;
		end else if (v_s2) begin
			sa_q  <= sa_q + a_s2;
			sb_q  <= sb_q + b_s2;
			saa_q <= saa_q + paa_s2;
			sbb_q <= sbb_q + pbb_s2;
			sab_q <= sab_q + pab_s2;
		end

		if (state_q == ST_PRODS) begin
			nsaa_q <= nsaa_c;
			nsbb_q <= nsbb_c;
			nsab_q <= nsab_c;
			sasa_q <= sasa_c;
			sbsb_q <= sbsb_c;
			sasb_q <= sasb_c;
		end
		if (state_q == ST_VARS) begin
			vaa_q <= nsaa_q - sasa_q;
			vbb_q <= nsbb_q - sbsb_q;
			vab_q <= nsab_q - sasb_q;
		end

		// The quotient register starts clean so its top bit is zero.
		if (state_q == ST_CHECK) begin
			flat_q <= flat_c;
			neg_q  <= vab_q[V-1];
			mx_q   <= (2*H)'(vaa_q[MW-1:0]);
			my_q   <= (2*H)'(vbb_q[MW-1:0]);
			quo_q  <= '0;
		end
		if (state_q == ST_MUL) begin
			pp_q  <= pp_c;
			psh_q <= psh_c;
			acc_q <= acc_next;
			if (mstep_q == 3'd4) begin
				if (!msel_q) begin
					p_q  <= acc_next[PW-1:0];
					mx_q <= (2*H)'(mag_c[MW-1:0]);
					my_q <= (2*H)'(mag_c[MW-1:0]);
				end else begin
					rem_q <= {1'b0, acc_next[PW-1:0]};
				end
			end
		end

		if (state_q == ST_DIV) begin
			rem_q <= div_ge ? div_sub : div_trial;
			quo_q <= {quo_q[QUO_W-2:0], div_ge};
		end
		if (state_q == ST_DIV && dcnt_q == 6'(DIV_STEPS - 1)) begin
			sq_src_q <= {quo_q[QUO_W-2:0], div_ge};
			root_q   <= '0;
			sqrem_q  <= '0;
		end
		if (state_q == ST_SQRT) begin
			sq_src_q <= {sq_src_q[QUO_W-3:0], 2'b00};
			sqrem_q  <= sq_ge ? sq_shift - sq_trial : sq_shift;
			root_q   <= {root_q[ROOT_W-2:0], sq_ge};
		end

		if (state_q == ST_FINISH && out_free) begin
			correlation_q   <= corr_c;
			first_row_q     <= ra_q;
			second_row_q    <= rb_q;
			zero_variance_q <= flat_q;
		end
	end

endmodule
